/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the sequence tracker.
// Each macro samples on aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, prop must hold as well.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/tcprst_pkg.sv */
// Types and constants of the TCP receive sequence tracker.
// No dependencies; used by tcp_receive_sequence_tracker_top.
`timescale 1ns / 1ps
`default_nettype none

package tcprst_pkg;

    typedef enum logic [1:0] {
        LINK_SYN_SENT = 2'd0,
        LINK_OPEN     = 2'd1,
        LINK_CLOSED   = 2'd2
    } link_state_t;

    localparam logic [1:0] CFG_LOCAL_ISEQ   = 2'd0;
    localparam logic [1:0] CFG_RECV_CAP     = 2'd1;
    localparam logic [1:0] CFG_RECV_PRESENT = 2'd2;

    localparam logic [15:0] RECV_CAP_RESET = 16'd4096;

    typedef struct packed {
        logic        cmd;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_rst;
        logic        flag_fin;
        logic [31:0] pkt_seq;
        logic [31:0] pkt_ack;
        logic [15:0] payload_len;
        logic [15:0] add_send_bytes;
        logic [15:0] consume_recv_bytes;
        logic        request_fin;
    } in_item_t;

    // Last member sits in the lowest bits, matching the result tdata layout.
    typedef struct packed {
        logic        fin_acked;
        logic        fin_received;
        logic [15:0] recv_fill;
        logic [15:0] pending_send;
        logic [31:0] ack_now;
        logic [31:0] seq_now;
        logic [15:0] released_bytes;
        logic [15:0] store_offset;
        logic        accept_data;
        logic        send_reset;
        logic [1:0]  ack_count;
        logic [1:0]  conn_state;
    } result_t;

endpackage

`default_nettype wire

/* rtl/tcp_receive_sequence_tracker_top.sv */
// Top level of the client-side TCP receive sequence tracker.
// Depends on tcprst_pkg and on assert_macros.svh.
//
// Usage: each request on the s_ channel is either a received packet (s_tuser = 0)
// or an application event (s_tuser = 1). Every request yields exactly one result
// on the m_ channel carrying the connection state, the acks and reset to send,
// data acceptance with its buffer offset, freed send bytes and the sequence
// counters after the request. The cfg_ channel writes the local initial
// sequence number, the receive capacity and the buffer-present flag; it is
// always ready and should be used only while no request is in flight.
// A request is captured in the input register; when it moves on, the connection
// state registers and the result register are loaded together. Throughput is
// one request per cycle while the receiver does not stall, as the state update
// between those two registers is combinational. When the receiver stalls, the
// result register holds, the input register keeps one more request, and
// s_tready falls once both are full. Reset (aresetn low, synchronous) returns
// the connection to SYN_SENT, clears all counters and flags, restores the
// register defaults and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcp_receive_sequence_tracker_top #(
    parameter int unsigned MAX_SEGMENT_SEND = 1024
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // flag_syn, flag_ack, flag_rst, flag_fin, pkt_seq[31:0], pkt_ack[31:0],
    // payload_len[15:0], add_send_bytes[15:0], consume_recv_bytes[15:0],
    // request_fin, zero pad[2:0]
    input  wire logic [119:0] s_tdata,
    // cmd
    input  wire logic [0:0]   s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // conn_state[1:0], ack_count[1:0], send_reset, accept_data,
    // store_offset[15:0], released_bytes[15:0], seq_now[31:0], ack_now[31:0],
    // pending_send[15:0], recv_fill[15:0], fin_received, fin_acked
    output logic [135:0]      m_tdata,

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    localparam logic [15:0] MSS = 16'(MAX_SEGMENT_SEND);

    logic [31:0] local_iseq_reg;
    logic [15:0] recv_cap_reg;
    logic        recv_present_reg;

    logic                   in_valid_reg;
    tcprst_pkg::in_item_t   in_item_reg;
    tcprst_pkg::in_item_t   in_item_next;
    logic                   out_valid_reg;
    tcprst_pkg::result_t    result_reg;
    tcprst_pkg::result_t    result_next;

    tcprst_pkg::link_state_t link_state_reg, link_state_next;
    logic [31:0] peer_iseq_reg, peer_iseq_next;
    logic [31:0] send_seq_reg, send_seq_next;
    logic [31:0] recv_ack_reg, recv_ack_next;
    logic [15:0] queued_reg, queued_next;
    logic [15:0] recv_level_reg, recv_level_next;
    logic        fin_wanted_reg, fin_wanted_next;
    logic        peer_fin_reg, peer_fin_next;
    logic        own_fin_acked_reg, own_fin_acked_next;

    logic        advance;
    logic        fire;

    logic [31:0] p_off, a_off, k_off, c_off, k_diff;
    logic [15:0] room, win;
    logic        fin_room;
    logic [32:0] win_end;
    logic        in_window;
    logic [16:0] take_raw, take_dec, take_cl;
    logic        fin_hit;
    logic        data_old, data_acc;
    logic        fin_new;
    logic [16:0] queued_sum;
    logic [1:0]  acks;
    logic        rst_out;
    logic [15:0] offset, released;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = result_reg;
    assign cfg_ready = 1'b1;

    assign in_item_next.cmd                = s_tuser[0];
    assign in_item_next.flag_syn           = s_tdata[0];
    assign in_item_next.flag_ack           = s_tdata[1];
    assign in_item_next.flag_rst           = s_tdata[2];
    assign in_item_next.flag_fin           = s_tdata[3];
    assign in_item_next.pkt_seq            = s_tdata[35:4];
    assign in_item_next.pkt_ack            = s_tdata[67:36];
    assign in_item_next.payload_len        = s_tdata[83:68];
    assign in_item_next.add_send_bytes     = s_tdata[99:84];
    assign in_item_next.consume_recv_bytes = s_tdata[115:100];
    assign in_item_next.request_fin        = s_tdata[116];

    always_comb begin
        p_off    = in_item_reg.pkt_seq - peer_iseq_reg;
        a_off    = recv_ack_reg - peer_iseq_reg;
        room     = (recv_level_reg < recv_cap_reg) ? recv_cap_reg - recv_level_reg : 16'd0;
        win      = (queued_reg < MSS) ? queued_reg : MSS;
        fin_room = fin_wanted_reg && !own_fin_acked_reg;
        k_off    = in_item_reg.pkt_ack - local_iseq_reg;
        c_off    = send_seq_reg - local_iseq_reg;
        win_end  = {1'b0, c_off} + {17'd0, win} + {32'd0, fin_room};
        in_window = (k_off > c_off) && ({1'b0, k_off} <= win_end);
        k_diff   = k_off - c_off;
        take_raw = k_diff[16:0];
        fin_hit  = (take_raw > {1'b0, queued_reg}) && fin_room;
        take_dec = take_raw - {16'd0, fin_hit};
        take_cl  = (take_dec > {1'b0, queued_reg}) ? {1'b0, queued_reg} : take_dec;

        data_old = (in_item_reg.payload_len != 16'd0) && (p_off < a_off);
        data_acc = (in_item_reg.payload_len != 16'd0) && (p_off == a_off)
                   && (!recv_present_reg || in_item_reg.payload_len <= room);
        fin_new  = in_item_reg.flag_fin && !peer_fin_reg;
        queued_sum = {1'b0, queued_reg} + {1'b0, in_item_reg.add_send_bytes};

        link_state_next    = link_state_reg;
        peer_iseq_next     = peer_iseq_reg;
        send_seq_next      = send_seq_reg;
        recv_ack_next      = recv_ack_reg;
        queued_next        = queued_reg;
        recv_level_next    = recv_level_reg;
        fin_wanted_next    = fin_wanted_reg;
        peer_fin_next      = peer_fin_reg;
        own_fin_acked_next = own_fin_acked_reg;
        acks     = 2'd0;
        rst_out  = 1'b0;
        offset   = 16'd0;
        released = 16'd0;

        if (in_item_reg.cmd) begin
            queued_next = queued_sum[16] ? 16'hFFFF : queued_sum[15:0];
            recv_level_next = (in_item_reg.consume_recv_bytes >= recv_level_reg) ? 16'd0
                              : recv_level_reg - in_item_reg.consume_recv_bytes;
            fin_wanted_next = fin_wanted_reg || in_item_reg.request_fin;
        end else begin
            case (link_state_reg)
                tcprst_pkg::LINK_SYN_SENT: begin
                    if (in_item_reg.flag_syn && in_item_reg.flag_ack) begin
                        if (in_item_reg.pkt_ack != local_iseq_reg + 32'd1) begin
                            rst_out = 1'b1;
                        end else begin
                            link_state_next = tcprst_pkg::LINK_OPEN;
                            peer_iseq_next  = in_item_reg.pkt_seq;
                            send_seq_next   = local_iseq_reg + 32'd1;
                            recv_ack_next   = in_item_reg.pkt_seq + 32'd1;
                            acks            = 2'd1;
                        end
                    end else if (in_item_reg.flag_rst) begin
                        link_state_next = tcprst_pkg::LINK_CLOSED;
                    end
                end
                tcprst_pkg::LINK_OPEN: begin
                    if (data_acc && recv_present_reg) begin
                        offset          = recv_level_reg;
                        recv_level_next = recv_level_reg + in_item_reg.payload_len;
                    end
                    recv_ack_next = recv_ack_reg
                                    + {16'd0, data_acc ? in_item_reg.payload_len : 16'd0}
                                    + {31'd0, fin_new};
                    if (in_item_reg.flag_ack && in_window) begin
                        queued_next   = queued_reg - take_cl[15:0];
                        released      = take_cl[15:0];
                        send_seq_next = send_seq_reg + {15'd0, take_cl} + {31'd0, fin_hit};
                        own_fin_acked_next = own_fin_acked_reg || fin_hit;
                    end
                    if (in_item_reg.flag_fin) begin
                        peer_fin_next = 1'b1;
                    end
                    acks = {1'b0, data_old || data_acc} + {1'b0, in_item_reg.flag_fin};
                end
                default: begin
                end
            endcase
        end

        result_next.conn_state     = link_state_next;
        result_next.ack_count      = acks;
        result_next.send_reset     = rst_out;
        result_next.accept_data    = data_acc && !in_item_reg.cmd
                                     && (link_state_reg == tcprst_pkg::LINK_OPEN);
        result_next.store_offset   = offset;
        result_next.released_bytes = released;
        result_next.seq_now        = send_seq_next;
        result_next.ack_now        = recv_ack_next;
        result_next.pending_send   = queued_next;
        result_next.recv_fill      = recv_level_next;
        result_next.fin_received   = peer_fin_next;
        result_next.fin_acked      = own_fin_acked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_iseq_reg   <= 32'd0;
            recv_cap_reg     <= tcprst_pkg::RECV_CAP_RESET;
            recv_present_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                tcprst_pkg::CFG_LOCAL_ISEQ:   local_iseq_reg   <= cfg_wdata;
                tcprst_pkg::CFG_RECV_CAP:     recv_cap_reg     <= cfg_wdata[15:0];
                tcprst_pkg::CFG_RECV_PRESENT: recv_present_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_state_reg    <= tcprst_pkg::LINK_SYN_SENT;
            peer_iseq_reg     <= 32'd0;
            send_seq_reg      <= 32'd0;
            recv_ack_reg      <= 32'd0;
            queued_reg        <= 16'd0;
            recv_level_reg    <= 16'd0;
            fin_wanted_reg    <= 1'b0;
            peer_fin_reg      <= 1'b0;
            own_fin_acked_reg <= 1'b0;
        end else if (fire) begin
            link_state_reg    <= link_state_next;
            peer_iseq_reg     <= peer_iseq_next;
            send_seq_reg      <= send_seq_next;
            recv_ack_reg      <= recv_ack_next;
            queued_reg        <= queued_next;
            recv_level_reg    <= recv_level_next;
            fin_wanted_reg    <= fin_wanted_next;
            peer_fin_reg      <= peer_fin_next;
            own_fin_acked_reg <= own_fin_acked_next;
        end
    end

    `ASSERT_NEXT(a_closed_sticky, link_state_reg == tcprst_pkg::LINK_CLOSED,
        link_state_reg == tcprst_pkg::LINK_CLOSED, "closed connection reopened")
    `ASSERT_IMPL(a_fin_ack_needs_fin, own_fin_acked_reg, fin_wanted_reg,
        "FIN acknowledged but never requested")
    `ASSERT_IMPL(a_reset_in_syn_sent, out_valid_reg && result_reg.send_reset,
        result_reg.conn_state == tcprst_pkg::LINK_SYN_SENT, "reset requested outside SYN_SENT")
    `ASSERT_NEXT(a_stalled_request_kept, in_valid_reg && !advance, in_valid_reg,
        "stalled request dropped from input register")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for tcp_receive_sequence_tracker_top.
// Depends on tcprst_pkg; drives random traffic with stalls on both channels
// and compares every result with a behavioural copy of the connection tracker.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned SEG_LIMIT = 1024;

    class conn_scoreboard;
        logic [31:0] local_iseq;
        logic [15:0] recv_cap;
        logic        buf_present;
        tcprst_pkg::link_state_t link;
        logic [31:0] peer_iseq;
        logic [31:0] snd_nxt;
        logic [31:0] rcv_nxt;
        logic [15:0] queued;
        logic [15:0] level;
        logic        fin_wanted;
        logic        peer_fin;
        logic        fin_acked;
        tcprst_pkg::result_t status_q[$];
        int          errors;
        int          requests;
        int          checked;
        int          taken_segs;
        int          releases;

        function new();
            local_iseq  = '0;
            recv_cap    = tcprst_pkg::RECV_CAP_RESET;
            buf_present = 1'b1;
            link        = tcprst_pkg::LINK_SYN_SENT;
            peer_iseq   = '0;
            snd_nxt     = '0;
            rcv_nxt     = '0;
            queued      = '0;
            level       = '0;
            fin_wanted  = 1'b0;
            peer_fin    = 1'b0;
            fin_acked   = 1'b0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                tcprst_pkg::CFG_LOCAL_ISEQ:   local_iseq = val;
                tcprst_pkg::CFG_RECV_CAP:     recv_cap = val[15:0];
                tcprst_pkg::CFG_RECV_PRESENT: buf_present = val[0];
                default: ;
            endcase
        endfunction

        // Advances the connection by one request and queues the status it must produce.
        function void note_request(tcprst_pkg::in_item_t r);
            tcprst_pkg::result_t e;
            logic [31:0] p_off;
            logic [31:0] a_off;
            logic [31:0] take;
            logic [33:0] k_off;
            logic [33:0] c_off;
            logic [33:0] win;
            logic [16:0] sum;
            logic [15:0] room;
            logic        fin_room;
            logic        fin_hit;
            e = '0;
            requests++;
            if (r.cmd) begin
                sum = {1'b0, queued} + {1'b0, r.add_send_bytes};
                queued = sum[16] ? 16'hFFFF : sum[15:0];
                level = (r.consume_recv_bytes >= level) ? 16'd0 : level - r.consume_recv_bytes;
                if (r.request_fin) fin_wanted = 1'b1;
            end else if (link == tcprst_pkg::LINK_SYN_SENT) begin
                if (r.flag_syn && r.flag_ack) begin
                    if (r.pkt_ack != local_iseq + 32'd1) begin
                        e.send_reset = 1'b1;
                    end else begin
                        link = tcprst_pkg::LINK_OPEN;
                        peer_iseq = r.pkt_seq;
                        snd_nxt = local_iseq + 32'd1;
                        rcv_nxt = r.pkt_seq + 32'd1;
                        e.ack_count = 2'd1;
                    end
                end else if (r.flag_rst) begin
                    link = tcprst_pkg::LINK_CLOSED;
                end
            end else if (link == tcprst_pkg::LINK_OPEN) begin
                if (r.payload_len != 16'd0) begin
                    p_off = r.pkt_seq - peer_iseq;
                    a_off = rcv_nxt - peer_iseq;
                    if (p_off < a_off) begin
                        e.ack_count = e.ack_count + 2'd1;
                    end else if (p_off == a_off) begin
                        room = (level < recv_cap) ? recv_cap - level : 16'd0;
                        if (!buf_present || r.payload_len <= room) begin
                            e.accept_data = 1'b1;
                            if (buf_present) begin
                                e.store_offset = level;
                                level = level + r.payload_len;
                            end
                            rcv_nxt = rcv_nxt + {16'd0, r.payload_len};
                            e.ack_count = e.ack_count + 2'd1;
                        end
                    end
                end
                if (r.flag_ack) begin
                    win = (queued < SEG_LIMIT) ? {18'd0, queued} : 34'(SEG_LIMIT);
                    fin_room = fin_wanted && !fin_acked;
                    k_off = {2'b00, r.pkt_ack - local_iseq};
                    c_off = {2'b00, snd_nxt - local_iseq};
                    if (k_off > c_off && k_off <= c_off + win + {33'd0, fin_room}) begin
                        take = 32'(k_off - c_off);
                        fin_hit = 1'b0;
                        if (take > {16'd0, queued} && fin_room) begin
                            take = take - 32'd1;
                            fin_hit = 1'b1;
                        end
                        if (take > {16'd0, queued}) take = {16'd0, queued};
                        queued = queued - take[15:0];
                        e.released_bytes = take[15:0];
                        snd_nxt = snd_nxt + take + {31'd0, fin_hit};
                        if (fin_hit) fin_acked = 1'b1;
                    end
                end
                if (r.flag_fin) begin
                    if (!peer_fin) begin
                        peer_fin = 1'b1;
                        rcv_nxt = rcv_nxt + 32'd1;
                    end
                    e.ack_count = e.ack_count + 2'd1;
                end
            end
            e.conn_state   = link;
            e.seq_now      = snd_nxt;
            e.ack_now      = rcv_nxt;
            e.pending_send = queued;
            e.recv_fill    = level;
            e.fin_received = peer_fin;
            e.fin_acked    = fin_acked;
            if (e.accept_data) taken_segs++;
            if (e.released_bytes != 16'd0) releases++;
            status_q.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(tcprst_pkg::result_t got);
            tcprst_pkg::result_t want;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, got %h", $time, got);
                return;
            end
            want = status_q.pop_front();
            checked++;
            compare_field("conn_state", 32'(want.conn_state), 32'(got.conn_state));
            compare_field("ack_count", 32'(want.ack_count), 32'(got.ack_count));
            compare_field("send_reset", 32'(want.send_reset), 32'(got.send_reset));
            compare_field("accept_data", 32'(want.accept_data), 32'(got.accept_data));
            compare_field("store_offset", 32'(want.store_offset), 32'(got.store_offset));
            compare_field("released_bytes", 32'(want.released_bytes),
                          32'(got.released_bytes));
            compare_field("seq_now", want.seq_now, got.seq_now);
            compare_field("ack_now", want.ack_now, got.ack_now);
            compare_field("pending_send", 32'(want.pending_send), 32'(got.pending_send));
            compare_field("recv_fill", 32'(want.recv_fill), 32'(got.recv_fill));
            compare_field("fin_received", 32'(want.fin_received), 32'(got.fin_received));
            compare_field("fin_acked", 32'(want.fin_acked), 32'(got.fin_acked));
        endfunction
    endclass

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [119:0]   s_tdata;
    logic [0:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [135:0]   m_tdata;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_addr;
    logic [31:0]    cfg_wdata;

    conn_scoreboard sb = new();
    bit             src_gaps;
    bit             sink_gaps;
    int             sink_hold;

    always #10 aclk = ~aclk;

    tcp_receive_sequence_tracker_top #(
        .MAX_SEGMENT_SEND(SEG_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    function automatic logic [119:0] pack_request(tcprst_pkg::in_item_t r);
        return {3'b000, r.request_fin, r.consume_recv_bytes, r.add_send_bytes, r.payload_len,
                r.pkt_ack, r.pkt_seq, r.flag_fin, r.flag_rst, r.flag_ack, r.flag_syn};
    endfunction

    function automatic tcprst_pkg::in_item_t pkt(logic syn, logic ackf, logic rst, logic fin,
                                     logic [31:0] seq, logic [31:0] ackn, logic [15:0] len);
        tcprst_pkg::in_item_t r;
        r = '0;
        r.flag_syn = syn;
        r.flag_ack = ackf;
        r.flag_rst = rst;
        r.flag_fin = fin;
        r.pkt_seq = seq;
        r.pkt_ack = ackn;
        r.payload_len = len;
        return r;
    endfunction

    function automatic tcprst_pkg::in_item_t app(logic [15:0] add_b, logic [15:0] cons_b,
                                                 logic fin);
        tcprst_pkg::in_item_t r;
        r = '0;
        r.cmd = 1'b1;
        r.add_send_bytes = add_b;
        r.consume_recv_bytes = cons_b;
        r.request_fin = fin;
        return r;
    endfunction

    // Mostly well-formed segments aimed at the current window, some events, a little noise.
    function automatic tcprst_pkg::in_item_t random_request();
        tcprst_pkg::in_item_t r;
        int unsigned pick;
        int unsigned win;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.cmd = 1'($urandom_range(0, 1));
            r.flag_syn = 1'($urandom_range(0, 1));
            r.flag_ack = 1'($urandom_range(0, 1));
            r.flag_rst = 1'($urandom_range(0, 1));
            r.flag_fin = 1'($urandom_range(0, 1));
            r.pkt_seq = $urandom;
            r.pkt_ack = $urandom;
            r.payload_len = 16'($urandom_range(0, 65535));
            r.add_send_bytes = 16'($urandom_range(0, 65535));
            r.consume_recv_bytes = 16'($urandom_range(0, 65535));
            r.request_fin = ($urandom_range(0, 15) == 0);
        end else if (pick < 30) begin
            r = app(16'($urandom_range(0, 700)), 16'($urandom_range(0, 1500)),
                    $urandom_range(0, 39) == 0);
        end else begin
            r.flag_ack = ($urandom_range(0, 3) != 0);
            r.flag_fin = ($urandom_range(0, 24) == 0);
            r.flag_syn = ($urandom_range(0, 19) == 0);
            r.flag_rst = ($urandom_range(0, 19) == 0);
            pick = $urandom_range(0, 9);
            r.pkt_seq = sb.rcv_nxt;
            if (pick <= 5) begin
                r.payload_len = 16'($urandom_range(1, 600));
            end else if (pick == 6) begin
                r.pkt_seq = sb.rcv_nxt - $urandom_range(1, 2000);
                r.payload_len = 16'($urandom_range(1, 600));
            end else if (pick == 7) begin
                r.pkt_seq = sb.rcv_nxt + $urandom_range(1, 2000);
                r.payload_len = 16'($urandom_range(1, 600));
            end else if (pick == 8) begin
                r.pkt_seq = $urandom;
            end else begin
                r.payload_len = 16'($urandom_range(1, 65535));
            end
            win = (sb.queued < SEG_LIMIT) ? {16'd0, sb.queued} : SEG_LIMIT;
            if (sb.fin_wanted && !sb.fin_acked) win++;
            pick = $urandom_range(0, 7);
            if (pick <= 4) begin
                r.pkt_ack = (win > 0) ? sb.snd_nxt + $urandom_range(1, win) : sb.snd_nxt;
            end else if (pick == 5) begin
                r.pkt_ack = sb.snd_nxt + win + $urandom_range(1, 100);
            end else if (pick == 6) begin
                r.pkt_ack = sb.snd_nxt - $urandom_range(0, 100);
            end else begin
                r.pkt_ack = $urandom;
            end
        end
        return r;
    endfunction

    task automatic send_request(tcprst_pkg::in_item_t r);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 14)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= pack_request(r);
        s_tuser <= r.cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, val);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.status_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(tcprst_pkg::result_t'(m_tdata));
    end

    initial begin : sink
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("Timed out with %0d results still awaited.", sb.status_q.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        sink_hold = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        cfg_write(tcprst_pkg::CFG_LOCAL_ISEQ, 32'hFFFF_FFFF);
        cfg_write(tcprst_pkg::CFG_RECV_CAP, 32'd4096);
        cfg_write(tcprst_pkg::CFG_RECV_PRESENT, 32'd1);

        // Handshake phase: events, ignored packets, bad acks, then the opening SYN+ACK.
        send_request(app(16'hFFFF, 16'hFFFF, 1'b0));
        send_request(app(16'hFFFF, 16'h0000, 1'b0));
        send_request(pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_1234, 32'h0, 16'd20));
        send_request(pkt(1'b0, 1'b0, 1'b0, 1'b1, 32'h0, 32'h0, 16'd0));
        send_request(pkt(1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0, 32'd5, 16'd0));
        send_request(pkt(1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'd0));
        send_request(pkt(1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0, 32'h0, 16'd0));

        // Open connection: in-order, old, future and empty segments, then window edges.
        send_request(pkt(1'b0, 1'b0, 1'b0, 1'b0, sb.rcv_nxt, 32'h0, 16'd100));
        send_request(pkt(1'b0, 1'b0, 1'b0, 1'b0, sb.peer_iseq + 32'd1, 32'h0, 16'd50));
        send_request(pkt(1'b0, 1'b0, 1'b0, 1'b0, sb.rcv_nxt + 32'd10, 32'h0, 16'd50));
        send_request(pkt(1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0));
        send_request(pkt(1'b1, 1'b0, 1'b1, 1'b0, sb.rcv_nxt, 32'h0, 16'hFFFF));
        send_request(pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h0, sb.snd_nxt + 32'd1025, 16'd0));
        send_request(pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h0, sb.snd_nxt + 32'd1024, 16'd0));
        send_request(pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h0, sb.snd_nxt, 16'd0));
        send_request(app(16'h0000, 16'hFFFF, 1'b1));
        send_request(pkt(1'b0, 1'b0, 1'b0, 1'b1, sb.rcv_nxt, 32'h0, 16'd0));
        send_request(pkt(1'b0, 1'b1, 1'b0, 1'b1, sb.rcv_nxt, sb.snd_nxt + 32'd3, 16'd4096));
        send_request(pkt(1'b0, 1'b0, 1'b0, 1'b0, sb.rcv_nxt, 32'h0, 16'd1));
        send_request(app(16'h0000, 16'hFFFF, 1'b0));

        for (int ph = 0; ph < 6; ph++) begin
            wait_for_results();
            case (ph)
                1: begin
                    cfg_write(tcprst_pkg::CFG_RECV_CAP, 32'd0);
                end
                2: begin
                    cfg_write(tcprst_pkg::CFG_LOCAL_ISEQ, $urandom);
                    cfg_write(tcprst_pkg::CFG_RECV_CAP, 32'd65535);
                end
                3: begin
                    cfg_write(tcprst_pkg::CFG_RECV_CAP, 32'd300);
                    cfg_write(tcprst_pkg::CFG_RECV_PRESENT, 32'd0);
                end
                4: begin
                    cfg_write(tcprst_pkg::CFG_LOCAL_ISEQ, 32'd0);
                    cfg_write(tcprst_pkg::CFG_RECV_PRESENT, 32'd1);
                end
                5: begin
                    cfg_write(tcprst_pkg::CFG_LOCAL_ISEQ, $urandom);
                    cfg_write(tcprst_pkg::CFG_RECV_CAP, $urandom_range(1, 65535));
                end
                default: ;
            endcase
            src_gaps = (ph == 0 || ph == 2 || ph == 3);
            sink_gaps = (ph == 0 || ph == 2 || ph == 4);
            for (int i = 0; i < 255; i++) begin
                if (ph == 2 && i == 100) begin
                    sink_hold = 60;
                    src_gaps = 1'b0;
                end
                if (ph == 2 && i == 140) src_gaps = 1'b1;
                if (ph == 4 && i == 120) wait_for_results();
                send_request(random_request());
            end
        end

        wait_for_results();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d requests and %0d checked results across six buffer settings,",
                 sb.requests, sb.checked);
        $display("with %0d segments taken in order, %0d acks freeing bytes, own FIN acked: %0d.",
                 sb.taken_segs, sb.releases, sb.fin_acked);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
